### design/sc2kc_pkg.sv
// Shared types and constants for the scancode-to-keycode translator.
// No dependencies; used by scancode_to_keycode_translator.

package sc2kc_pkg;

    localparam int CODE_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int HIGH_DEPTH = 39;
    localparam int ESC_DEPTH  = 128;
    localparam int HIGH_IDX_W = $clog2(HIGH_DEPTH);

    typedef logic [OP_W-1:0]       opcode_t;
    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [HIGH_IDX_W-1:0] high_idx_t;

    // Opcodes
    localparam opcode_t OP_TRANSLATE = 2'd0;
    localparam opcode_t OP_WRITE     = 2'd1;
    localparam opcode_t OP_READ      = 2'd2;

    // Prefix tracker
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_E0,
        PFX_E1,
        PFX_E1_1D
    } prefix_t;

    // Special bytes and codes
    localparam byte_t BYTE_E0    = 8'he0;
    localparam byte_t BYTE_E1    = 8'he1;
    localparam byte_t BYTE_CLR0  = 8'h00;
    localparam byte_t BYTE_CLRFF = 8'hff;
    localparam code_t CODE_1D    = 7'h1d;
    localparam code_t CODE_45    = 7'h45;
    localparam code_t CODE_LSHFT = 7'h2a;
    localparam code_t CODE_RSHFT = 7'h36;
    localparam code_t HIGH_BASE  = 7'd89;
    localparam code_t PAUSE_KEY  = 7'd119;

    // Power-on contents of the high-code map (codes 89..127)
    localparam code_t HIGH_DEFAULT [HIGH_DEPTH] = '{
        7'd124, 7'd125, 7'd126, 7'd127, 7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd122, 7'd0,   7'd123,
        7'd0,   7'd0,   7'd0,   7'd89,  7'd120, 7'd0,   7'd0,   7'd90,
        7'd91,  7'd92,  7'd93,  7'd94,
        7'd95,  7'd124, 7'd121, 7'd0
    };

    // Power-on contents of the E0-escaped map
    localparam code_t ESC_DEFAULT [ESC_DEPTH] = '{
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd96,  7'd97,  7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd98,  7'd0,   7'd99,
        7'd100, 7'd0,   7'd0,   7'd0,   7'd0,   7'd113, 7'd114, 7'd115,
        7'd116, 7'd117, 7'd0,   7'd0,   7'd0,   7'd0,   7'd101, 7'd102,
        7'd103, 7'd104, 7'd0,   7'd105, 7'd124, 7'd106, 7'd118, 7'd107,
        7'd108, 7'd109, 7'd110, 7'd111, 7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd125, 7'd126, 7'd127, 7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd112,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
    };

endpackage

### design/scancode_to_keycode_translator.sv
// Top level of the PC/AT set 1 scancode-to-keycode translator.
// Depends on sc2kc_pkg and sc2kc_ram.

// Translates raw set 1 scan bytes into 7-bit keycodes and lets software
// rewrite or read back the two remap tables. Every input transaction gives
// exactly one result transaction. The block takes one transaction per clock
// while m_tready does not hold back the result register. The remap RAMs
// (one read port each) are read while the input is registered into stage 1;
// then prefix state and table data are resolved from stage 1 into the
// result register. Prefix bytes E0 and E1 arm the prefix tracker; 00 and FF
// clear it; E0 codes go through the escaped map (fake shifts 2A/36 are
// swallowed); unprefixed codes 89..127 go through the high-code map; lower
// codes pass through; E1 1D 45 gives Pause (119). A zero map entry means no
// key. Map writes (opcode 1) and reads (opcode 2) take scancode 89..127 for
// the high map and 128..255 for the escaped map; a scancode below 89 is
// refused with status 1. Both maps come out of reset holding their default
// tables at once: per-entry valid bits select the constant default until an
// entry is written, so no clearing pass is needed.

module scancode_to_keycode_translator (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] scan_byte, [14:8] new_keycode, [15] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] keycode, [7] status
    output logic        m_tuser    // [0] key_valid
);

    // ------------------------------------------------------------------
    // Handshake: stage 1 holds the accepted transaction and its RAM data,
    // the result register feeds the master side.
    // ------------------------------------------------------------------
    logic s_accept;
    logic advance;
    logic s1_fire;
    logic s1_valid_reg;
    logic m_tvalid_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && advance;

    // ------------------------------------------------------------------
    // Input decode; table writes land at accept time so the next
    // transaction's read already sees them.
    // ------------------------------------------------------------------
    sc2kc_pkg::opcode_t   in_op;
    sc2kc_pkg::byte_t     in_byte;
    sc2kc_pkg::code_t     in_nk;
    sc2kc_pkg::code_t     in_code;
    sc2kc_pkg::code_t     in_high_diff;
    sc2kc_pkg::high_idx_t in_high_idx;
    logic                 in_high_hit;
    logic                 esc_we;
    logic                 high_we;

    assign in_op        = s_tuser;
    assign in_byte      = s_tdata[7:0];
    assign in_nk        = s_tdata[14:8];
    assign in_code      = in_byte[6:0];
    assign in_high_hit  = (in_code >= sc2kc_pkg::HIGH_BASE);
    assign in_high_diff = in_code - sc2kc_pkg::HIGH_BASE;
    assign in_high_idx  = in_high_hit ? in_high_diff[sc2kc_pkg::HIGH_IDX_W-1:0] : '0;

    assign esc_we  = s_accept && (in_op == sc2kc_pkg::OP_WRITE) && in_byte[7];
    assign high_we = s_accept && (in_op == sc2kc_pkg::OP_WRITE) && !in_byte[7]
                     && in_high_hit;

    sc2kc_pkg::code_t esc_rdata;
    sc2kc_pkg::code_t high_rdata;

    sc2kc_ram #(
        .WIDTH (sc2kc_pkg::CODE_W),
        .DEPTH (sc2kc_pkg::ESC_DEPTH)
    ) u_esc_ram (
        .aclk  (aclk),
        .we    (esc_we),
        .waddr (in_code),
        .wdata (in_nk),
        .re    (s_accept),
        .raddr (in_code),
        .rdata (esc_rdata)
    );

    sc2kc_ram #(
        .WIDTH (sc2kc_pkg::CODE_W),
        .DEPTH (sc2kc_pkg::HIGH_DEPTH)
    ) u_high_ram (
        .aclk  (aclk),
        .we    (high_we),
        .waddr (in_high_idx),
        .wdata (in_nk),
        .re    (s_accept),
        .raddr (in_high_idx),
        .rdata (high_rdata)
    );

    // Written-entry flags: a clear flag means the entry still holds its default.
    logic [sc2kc_pkg::ESC_DEPTH-1:0]  esc_vld_reg;
    logic [sc2kc_pkg::HIGH_DEPTH-1:0] high_vld_reg;
    logic                             esc_v_reg;
    logic                             high_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_vld_reg  <= '0;
            high_vld_reg <= '0;
        end else begin
            if (esc_we) begin
                esc_vld_reg[in_code] <= 1'b1;
            end
            if (high_we) begin
                high_vld_reg[in_high_idx] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 register
    // ------------------------------------------------------------------
    sc2kc_pkg::opcode_t s1_op_reg;
    sc2kc_pkg::byte_t   s1_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg   <= in_op;
            s1_byte_reg <= in_byte;
            esc_v_reg   <= esc_vld_reg[in_code];
            high_v_reg  <= in_high_hit && high_vld_reg[in_high_idx];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 resolve: merge RAM data with defaults
    // ------------------------------------------------------------------
    sc2kc_pkg::code_t     s1_code;
    sc2kc_pkg::code_t     s1_high_diff;
    sc2kc_pkg::high_idx_t s1_high_idx;
    logic                 s1_high_hit;
    sc2kc_pkg::code_t     esc_val;
    sc2kc_pkg::code_t     high_val;

    assign s1_code      = s1_byte_reg[6:0];
    assign s1_high_hit  = (s1_code >= sc2kc_pkg::HIGH_BASE);
    assign s1_high_diff = s1_code - sc2kc_pkg::HIGH_BASE;
    assign s1_high_idx  = s1_high_hit ? s1_high_diff[sc2kc_pkg::HIGH_IDX_W-1:0] : '0;

    assign esc_val  = esc_v_reg ? esc_rdata : sc2kc_pkg::ESC_DEFAULT[s1_code];
    assign high_val = high_v_reg ? high_rdata : sc2kc_pkg::HIGH_DEFAULT[s1_high_idx];

    // ------------------------------------------------------------------
    // Prefix tracker: next state
    // ------------------------------------------------------------------
    sc2kc_pkg::prefix_t prefix_reg;
    sc2kc_pkg::prefix_t prefix_next;

    always_comb begin
        prefix_next = prefix_reg;
        if (s1_fire && (s1_op_reg == sc2kc_pkg::OP_TRANSLATE)) begin
            if (s1_byte_reg == sc2kc_pkg::BYTE_E0) begin
                prefix_next = sc2kc_pkg::PFX_E0;
            end else if (s1_byte_reg == sc2kc_pkg::BYTE_E1) begin
                prefix_next = sc2kc_pkg::PFX_E1;
            end else begin
                case (prefix_reg)
                    sc2kc_pkg::PFX_E1: begin
                        if ((s1_code == sc2kc_pkg::CODE_1D)
                            && (s1_byte_reg != sc2kc_pkg::BYTE_CLRFF)) begin
                            prefix_next = sc2kc_pkg::PFX_E1_1D;
                        end else begin
                            prefix_next = sc2kc_pkg::PFX_NONE;
                        end
                    end
                    default: begin
                        prefix_next = sc2kc_pkg::PFX_NONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= sc2kc_pkg::PFX_NONE;
        end else begin
            prefix_reg <= prefix_next;
        end
    end

    // ------------------------------------------------------------------
    // Result of the stage 1 transaction
    // ------------------------------------------------------------------
    logic             res_key_valid;
    sc2kc_pkg::code_t res_keycode;
    logic             res_status;
    logic             map_refused;

    // Table access below scancode 89 has no entry behind it
    assign map_refused = !s1_byte_reg[7] && !s1_high_hit;

    always_comb begin
        res_key_valid = 1'b0;
        res_keycode   = '0;
        res_status    = 1'b0;
        case (s1_op_reg)
            sc2kc_pkg::OP_TRANSLATE: begin
                if (s1_byte_reg inside {sc2kc_pkg::BYTE_E0, sc2kc_pkg::BYTE_E1,
                                        sc2kc_pkg::BYTE_CLR0, sc2kc_pkg::BYTE_CLRFF}) begin
                    res_key_valid = 1'b0;
                end else begin
                    case (prefix_reg)
                        sc2kc_pkg::PFX_E0: begin
                            if (!(s1_code inside {sc2kc_pkg::CODE_LSHFT,
                                                  sc2kc_pkg::CODE_RSHFT})) begin
                                res_key_valid = |esc_val;
                                res_keycode   = esc_val;
                            end
                        end
                        sc2kc_pkg::PFX_E1_1D: begin
                            if (s1_code == sc2kc_pkg::CODE_45) begin
                                res_key_valid = 1'b1;
                                res_keycode   = sc2kc_pkg::PAUSE_KEY;
                            end
                        end
                        sc2kc_pkg::PFX_NONE: begin
                            if (s1_high_hit) begin
                                res_key_valid = |high_val;
                                res_keycode   = high_val;
                            end else begin
                                res_key_valid = 1'b1;
                                res_keycode   = s1_code;
                            end
                        end
                        default: begin
                            res_key_valid = 1'b0;   // broken E1 sequence
                        end
                    endcase
                end
            end
            sc2kc_pkg::OP_WRITE: begin
                res_status = map_refused;
            end
            sc2kc_pkg::OP_READ: begin
                res_status = map_refused;
                if (!map_refused) begin
                    res_keycode = s1_byte_reg[7] ? esc_val : high_val;
                end
            end
            default: begin
                res_status = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic             m_key_valid_reg;
    sc2kc_pkg::code_t m_keycode_reg;
    logic             m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_key_valid_reg <= res_key_valid;
            m_keycode_reg   <= res_keycode;
            m_status_reg    <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_status_reg, m_keycode_reg};
    assign m_tuser  = m_key_valid_reg;

endmodule

### design/sc2kc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sc2kc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
